@@ hdl/qpv_pkg.sv @@
// ----------------------------------------------------------------------------
// qpv_pkg: shared types and constants of the quadrature pass validator
// Register map indexes, the X4 step code and the transition decode.
// ----------------------------------------------------------------------------
package qpv_pkg;

  localparam int unsigned RegCount = 2;
  localparam int unsigned RegIdxWidth = 1;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [RegIdxWidth-1:0] REG_REVERSE_TOL = 1'b0;
  localparam logic [RegIdxWidth-1:0] REG_PASS_THRESH = 1'b1;

  localparam int unsigned RevTolWidth = 8;
  localparam int unsigned ThreshWidth = 12;
  localparam logic [RevTolWidth-1:0] RevTolReset = 8'd12;
  localparam logic [ThreshWidth-1:0] ThreshReset = 12'd60;

  localparam int unsigned OutCountWidth = 16;
  localparam int unsigned OutPeakWidth = 16;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_e;

  // Encoder state is {A, B}. Unlisted transitions are either no change or
  // a double transition, and both count as no step.
  function automatic step_e qpv_step(input logic [1:0] prev_ab, input logic [1:0] ab);
    step_e res;
    res = STEP_NONE;
    case ({prev_ab, ab}) inside
      4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: res = STEP_UP;
      4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: res = STEP_DOWN;
      default: res = STEP_NONE;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/quadrature_pass_validator.sv @@
// ----------------------------------------------------------------------------
// quadrature_pass_validator: X4 quadrature decoder with pass validation
// Tracks position and peak excursion, flags reversals and counts passes.
// ----------------------------------------------------------------------------
// Each input beat carries one sample of encoder channels A and B and of the
// index sensor, and produces exactly one output beat that shows the state
// after that sample. A new beat is accepted in every cycle unless the input
// is stalled; the whole update is one pass of logic from the state registers
// back into them, and the output beat is read from those registers, so a
// result shows in the cycle after its input. Backpressure on the output
// stalls the input only while the pending result is not being taken.
// Configuration writes through the APB port take effect on the next beat and must only be issued while idle.
module quadrature_pass_validator #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic enc_a_i,
  input  logic enc_b_i,
  input  logic at_index_i,

  output logic out_valid_o,
  input  logic out_ready_i,
  output logic led_cw_o,
  output logic led_ccw_o,
  output logic cw_toggle_o,
  output logic ccw_toggle_o,
  output logic [qpv_pkg::OutCountWidth-1:0] count_cw_o,
  output logic [qpv_pkg::OutCountWidth-1:0] count_ccw_o,
  output logic [qpv_pkg::OutCountWidth-1:0] count_fail_o,
  output logic signed [qpv_pkg::OutPeakWidth-1:0] peak_position_o,
  output logic reverse_seen_o,
  output logic at_end_o,

  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [qpv_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [qpv_pkg::CfgDataWidth-1:0] pwdata,
  output logic [qpv_pkg::CfgDataWidth-1:0] prdata,
  output logic pready
);
  import qpv_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned DW = POSITION_WIDTH + 1;
  localparam int unsigned TW = (POSITION_WIDTH > ThreshWidth) ? POSITION_WIDTH + 1
                                                              : ThreshWidth + 2;
  localparam logic signed [PW-1:0] PosMax = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PosMin = {1'b1, {(PW-1){1'b0}}};

  logic [RevTolWidth-1:0] rev_tol_q;
  logic [ThreshWidth-1:0] thresh_q;

  logic [1:0] prev_ab_q, prev_ab_d;
  logic signed [PW-1:0] position_q, position_d;
  logic signed [PW-1:0] peak_q, peak_d;
  logic dir_pos_q, dir_pos_d;
  logic invalid_q, invalid_d;
  logic [1:0] led_q, led_d;
  logic [1:0] toggle_q, toggle_d;
  logic [COUNT_WIDTH-1:0] count_cw_q, count_cw_d;
  logic [COUNT_WIDTH-1:0] count_ccw_q, count_ccw_d;
  logic [COUNT_WIDTH-1:0] count_fail_q, count_fail_d;
  logic at_end_q;
  logic out_valid_q;

  logic in_accept;
  logic cfg_write;
  logic [RegIdxWidth-1:0] cfg_idx;
  logic [1:0] ab;
  step_e step;

  logic signed [PW-1:0] pos_step;
  logic [PW-1:0] mag_pos;
  logic [PW-1:0] mag_peak;
  logic signed [PW-1:0] peak_upd;
  logic dir_upd;
  logic signed [DW-1:0] diff;
  logic [DW-1:0] mag_diff;
  logic signed [TW-1:0] peak_ext;
  logic signed [TW-1:0] thr_ext;
  logic [31:0] cw_ext;
  logic [31:0] ccw_ext;
  logic [31:0] fail_ext;
  logic signed [31:0] peak_wide;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept = in_valid_i && in_ready_o;
  assign ab = {enc_a_i, enc_b_i};
  assign step = qpv_step(prev_ab_q, ab);

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];

  always_comb begin
    unique case (cfg_idx)
      REG_REVERSE_TOL: prdata = CfgDataWidth'(rev_tol_q);
      REG_PASS_THRESH: prdata = CfgDataWidth'(thresh_q);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    pos_step = position_q;
    if (step == STEP_UP && position_q != PosMax) begin
      pos_step = position_q + PW'(1);
    end else if (step == STEP_DOWN && position_q != PosMin) begin
      pos_step = position_q - PW'(1);
    end
    mag_pos = pos_step[PW-1] ? (~pos_step + PW'(1)) : pos_step;
    mag_peak = peak_q[PW-1] ? (~peak_q + PW'(1)) : peak_q;
    if (mag_peak < mag_pos) begin
      peak_upd = pos_step;
      dir_upd = (step == STEP_UP);
    end else begin
      peak_upd = peak_q;
      dir_upd = dir_pos_q;
    end
    diff = DW'(peak_upd) - DW'(pos_step);
    mag_diff = diff[DW-1] ? (~diff + DW'(1)) : diff;
    peak_ext = TW'(peak_q);
    thr_ext = signed'(TW'(thresh_q));
  end

  always_comb begin
    prev_ab_d = prev_ab_q;
    position_d = position_q;
    peak_d = peak_q;
    dir_pos_d = dir_pos_q;
    invalid_d = invalid_q;
    led_d = led_q;
    toggle_d = toggle_q;
    count_cw_d = count_cw_q;
    count_ccw_d = count_ccw_q;
    count_fail_d = count_fail_q;
    if (in_accept) begin
      prev_ab_d = ab;
      if (step != STEP_NONE) begin
        if (at_index_i) begin
          if (!invalid_q) begin
            if (peak_ext > thr_ext) begin
              toggle_d[0] = !toggle_q[0];
              count_cw_d = count_cw_q + COUNT_WIDTH'(1);
            end
            if (peak_ext < -thr_ext) begin
              toggle_d[1] = !toggle_q[1];
              count_ccw_d = count_ccw_q + COUNT_WIDTH'(1);
            end
          end else begin
            count_fail_d = count_fail_q + COUNT_WIDTH'(1);
          end
          position_d = '0;
          peak_d = '0;
          invalid_d = 1'b0;
          led_d = 2'b00;
        end else begin
          position_d = pos_step;
          peak_d = peak_upd;
          dir_pos_d = dir_upd;
          if (mag_diff > DW'(rev_tol_q)) begin
            position_d = '0;
            invalid_d = 1'b1;
          end
          if (invalid_d) begin
            led_d = 2'b11;
          end else if (dir_upd) begin
            led_d = 2'b01;
          end else begin
            led_d = 2'b10;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_tol_q <= RevTolReset;
      thresh_q <= ThreshReset;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_REVERSE_TOL: rev_tol_q <= pwdata[RevTolWidth-1:0];
        REG_PASS_THRESH: thresh_q <= pwdata[ThreshWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ab_q <= '0;
      position_q <= '0;
      peak_q <= '0;
      dir_pos_q <= 1'b0;
      invalid_q <= 1'b0;
      led_q <= '0;
      toggle_q <= '0;
      count_cw_q <= '0;
      count_ccw_q <= '0;
      count_fail_q <= '0;
      at_end_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_ab_q <= prev_ab_d;
      position_q <= position_d;
      peak_q <= peak_d;
      dir_pos_q <= dir_pos_d;
      invalid_q <= invalid_d;
      led_q <= led_d;
      toggle_q <= toggle_d;
      count_cw_q <= count_cw_d;
      count_ccw_q <= count_ccw_d;
      count_fail_q <= count_fail_d;
      if (in_accept) begin
        at_end_q <= at_index_i;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cw_ext = 32'(count_cw_q);
  assign ccw_ext = 32'(count_ccw_q);
  assign fail_ext = 32'(count_fail_q);
  assign peak_wide = 32'(peak_q);

  assign out_valid_o = out_valid_q;
  assign led_cw_o = led_q[0];
  assign led_ccw_o = led_q[1];
  assign cw_toggle_o = toggle_q[0];
  assign ccw_toggle_o = toggle_q[1];
  assign count_cw_o = cw_ext[OutCountWidth-1:0];
  assign count_ccw_o = ccw_ext[OutCountWidth-1:0];
  assign count_fail_o = fail_ext[OutCountWidth-1:0];
  assign peak_position_o = peak_wide[OutPeakWidth-1:0];
  assign reverse_seen_o = invalid_q;
  assign at_end_o = at_end_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    invalid_q |-> led_q == 2'b11)
    else $error("Invalid pass without both LEDs lit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(count_cw_q) && $stable(count_ccw_q) && $stable(count_fail_q))
    else $error("Pass counter changed without an input beat.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && invalid_q |=> $stable(count_cw_q) && $stable(count_ccw_q))
    else $error("Valid pass counted while the pass was invalid.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("Input stalled with no pending result.");
`endif

endmodule

@@ dv/tb_quadrature_pass_validator.sv @@
// ----------------------------------------------------------------------------
// tb_quadrature_pass_validator: self-checking bench for the pass validator
// Sends encoder samples through the input channel under varied idle and
// stall patterns, predicts every output beat from a model of the decoder,
// and compares each field. Covers reset values, register writes and reads,
// reversals, double transitions, index hits and pass counting.
// ----------------------------------------------------------------------------
module tb_quadrature_pass_validator;
  import qpv_pkg::*;

  typedef struct packed {
    logic a;
    logic b;
    logic idx;
  } enc_sample_t;

  typedef struct {
    logic led_cw;
    logic led_ccw;
    logic cw_tgl;
    logic ccw_tgl;
    logic [OutCountWidth-1:0] n_cw;
    logic [OutCountWidth-1:0] n_ccw;
    logic [OutCountWidth-1:0] n_fail;
    logic signed [OutPeakWidth-1:0] peak;
    logic rev;
    logic at_end;
  } pass_status_t;

  localparam int PosMax = 32767;
  localparam int PosMin = -32768;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic enc_a_i;
  logic enc_b_i;
  logic at_index_i;
  logic out_valid_o;
  logic out_ready_i;
  logic led_cw_o;
  logic led_ccw_o;
  logic cw_toggle_o;
  logic ccw_toggle_o;
  logic [OutCountWidth-1:0] count_cw_o;
  logic [OutCountWidth-1:0] count_ccw_o;
  logic [OutCountWidth-1:0] count_fail_o;
  logic signed [OutPeakWidth-1:0] peak_position_o;
  logic reverse_seen_o;
  logic at_end_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic pready;

  enc_sample_t sample_q[$];
  pass_status_t status_q[$];
  enc_sample_t next_sample;
  pass_status_t want;

  int mismatches = 0;
  int queued_samples = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit in_beat_taken = 1'b0;
  logic [1:0] gen_ab = 2'b00;

  logic [RevTolWidth-1:0] tol_cfg = RevTolReset;
  logic [ThreshWidth-1:0] thr_cfg = ThreshReset;
  logic [1:0] seen_ab = 2'b00;
  int cur_pos = 0;
  int pk = 0;
  bit pk_up = 1'b0;
  bit bad_pass = 1'b0;
  logic [1:0] leds = 2'b00;
  logic [1:0] toggles = 2'b00;
  logic [OutCountWidth-1:0] n_cw = '0;
  logic [OutCountWidth-1:0] n_ccw = '0;
  logic [OutCountWidth-1:0] n_fail = '0;

  quadrature_pass_validator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .enc_a_i        (enc_a_i),
    .enc_b_i        (enc_b_i),
    .at_index_i     (at_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .led_cw_o       (led_cw_o),
    .led_ccw_o      (led_ccw_o),
    .cw_toggle_o    (cw_toggle_o),
    .ccw_toggle_o   (ccw_toggle_o),
    .count_cw_o     (count_cw_o),
    .count_ccw_o    (count_ccw_o),
    .count_fail_o   (count_fail_o),
    .peak_position_o(peak_position_o),
    .reverse_seen_o (reverse_seen_o),
    .at_end_o       (at_end_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [1:0] ab_forward(logic [1:0] ab);
    case (ab)
      2'b00: return 2'b10;
      2'b10: return 2'b11;
      2'b11: return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

  function automatic logic [1:0] ab_backward(logic [1:0] ab);
    case (ab)
      2'b10: return 2'b00;
      2'b11: return 2'b10;
      2'b01: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  function automatic step_e x4_decode(logic [1:0] from, logic [1:0] to);
    if (to == ab_forward(from)) begin
      return STEP_UP;
    end
    if (to == ab_backward(from)) begin
      return STEP_DOWN;
    end
    return STEP_NONE;
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Advances the decoder state by one encoder sample and records the
  // status beat that the block must report for it.
  function automatic void track_sample(enc_sample_t s);
    step_e stp;
    int thr;
    pass_status_t st;
    stp = x4_decode(seen_ab, {s.a, s.b});
    thr = int'(thr_cfg);
    seen_ab = {s.a, s.b};
    if (stp != STEP_NONE) begin
      if (s.idx) begin
        if (!bad_pass) begin
          if (pk > thr) begin
            toggles[0] = ~toggles[0];
            n_cw = n_cw + OutCountWidth'(1);
          end
          if (pk < -thr) begin
            toggles[1] = ~toggles[1];
            n_ccw = n_ccw + OutCountWidth'(1);
          end
        end else begin
          n_fail = n_fail + OutCountWidth'(1);
        end
        cur_pos = 0;
        pk = 0;
        bad_pass = 1'b0;
        leds = 2'b00;
      end else begin
        if (stp == STEP_UP && cur_pos < PosMax) begin
          cur_pos++;
        end else if (stp == STEP_DOWN && cur_pos > PosMin) begin
          cur_pos--;
        end
        if (magnitude(pk) < magnitude(cur_pos)) begin
          pk = cur_pos;
          pk_up = (stp == STEP_UP);
        end
        if (magnitude(pk - cur_pos) > int'(tol_cfg)) begin
          cur_pos = 0;
          bad_pass = 1'b1;
        end
        if (bad_pass) begin
          leds = 2'b11;
        end else if (pk_up) begin
          leds = 2'b01;
        end else begin
          leds = 2'b10;
        end
      end
    end
    st.led_cw = leds[0];
    st.led_ccw = leds[1];
    st.cw_tgl = toggles[0];
    st.ccw_tgl = toggles[1];
    st.n_cw = n_cw;
    st.n_ccw = n_ccw;
    st.n_fail = n_fail;
    st.peak = pk[OutPeakWidth-1:0];
    st.rev = bad_pass;
    st.at_end = s.idx;
    status_q.push_back(st);
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_sample('{enc_a_i, enc_b_i, at_index_i});
        in_beat_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          mismatches++;
          $display("%0t: output beat with no expected status, expected none, actual %0d",
                   $time, count_cw_o);
        end else begin
          want = status_q.pop_front();
          check_field("led_cw", int'(want.led_cw), int'(led_cw_o));
          check_field("led_ccw", int'(want.led_ccw), int'(led_ccw_o));
          check_field("cw_toggle", int'(want.cw_tgl), int'(cw_toggle_o));
          check_field("ccw_toggle", int'(want.ccw_tgl), int'(ccw_toggle_o));
          check_field("count_cw", int'(want.n_cw), int'(count_cw_o));
          check_field("count_ccw", int'(want.n_ccw), int'(count_ccw_o));
          check_field("count_fail", int'(want.n_fail), int'(count_fail_o));
          check_field("peak_position", int'(want.peak), int'(peak_position_o));
          check_field("reverse_seen", int'(want.rev), int'(reverse_seen_o));
          check_field("at_end", int'(want.at_end), int'(at_end_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_beat_taken)) begin
      in_beat_taken = 1'b0;
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = sample_q.pop_front();
        in_valid_i <= 1'b1;
        enc_a_i <= next_sample.a;
        enc_b_i <= next_sample.b;
        at_index_i <= next_sample.idx;
      end else begin
        in_valid_i <= 1'b0;
        enc_a_i <= 1'($urandom_range(1));
        enc_b_i <= 1'($urandom_range(1));
        at_index_i <= 1'($urandom_range(1));
      end
    end
  end

  // The long hold-off is counted here so that the sender keeps offering
  // beats while the output side is blocked.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic add_sample(logic a, logic b, logic idx);
    sample_q.push_back('{a, b, idx});
    gen_ab = {a, b};
    queued_samples++;
  endtask

  task automatic add_step(bit fwd, logic idx);
    logic [1:0] nxt;
    nxt = fwd ? ab_forward(gen_ab) : ab_backward(gen_ab);
    add_sample(nxt[1], nxt[0], idx);
  endtask

  task automatic add_double(logic idx);
    logic [1:0] nxt;
    nxt = gen_ab ^ 2'b11;
    add_sample(nxt[1], nxt[0], idx);
  endtask

  // One travel toward the index: mostly steady steps, sometimes a fall-back
  // partway, sometimes an early index hit, then a step at the index.
  task automatic add_pass_travel();
    bit fwd;
    int len;
    int back;
    int tol_cap;
    fwd = 1'($urandom_range(1));
    len = int'(thr_cfg) + $urandom_range(0, 8) - 2;
    if (len < 1) begin
      len = 1;
    end
    tol_cap = (int'(tol_cfg) < 10) ? int'(tol_cfg) : 10;
    for (int i = 0; i < len; i++) begin
      add_step(fwd, ($urandom_range(99) < 2));
      if (i == len / 2 && $urandom_range(99) < 30) begin
        back = $urandom_range(1, tol_cap + 2);
        repeat (back) add_step(!fwd, 1'b0);
      end
    end
    if ($urandom_range(99) < 25) begin
      add_sample(gen_ab[1], gen_ab[0], 1'b1);
    end
    add_step(1'($urandom_range(1)), 1'b1);
  endtask

  task automatic set_register(logic [RegIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
    logic [CfgDataWidth-1:0] mask;
    logic [CfgDataWidth-1:0] stored;
    mask = (idx == REG_REVERSE_TOL) ? (1 << RevTolWidth) - 1 : (1 << ThreshWidth) - 1;
    stored = value & mask;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= stored | ($urandom() & ~mask);
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (idx == REG_REVERSE_TOL) begin
      tol_cfg = stored[RevTolWidth-1:0];
    end else begin
      thr_cfg = stored[ThreshWidth-1:0];
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (prdata !== stored) begin
      mismatches++;
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h", $time,
               idx, stored, prdata);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (!(sample_q.size() == 0 && !in_valid_i && status_q.size() == 0));
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    int start;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    enc_a_i = 1'b0;
    enc_b_i = 1'b0;
    at_index_i = 1'b0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats with the reset register values.
    add_sample(1'b0, 1'b0, 1'b0);
    add_sample(1'b0, 1'b0, 1'b1);
    add_step(1'b1, 1'b0);
    repeat (3) add_step(1'b0, 1'b0);
    add_double(1'b0);
    add_double(1'b1);
    add_step(1'b1, 1'b1);
    wait_idle();

    set_register(REG_REVERSE_TOL, 1);
    set_register(REG_PASS_THRESH, 1);
    repeat (2) add_step(1'b1, 1'b0);
    repeat (2) add_step(1'b0, 1'b0);
    add_step(1'b1, 1'b1);
    repeat (2) add_step(1'b1, 1'b0);
    add_step(1'b1, 1'b1);
    repeat (2) add_step(1'b0, 1'b0);
    add_step(1'b0, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_register(REG_REVERSE_TOL, 255);
          set_register(REG_PASS_THRESH, 0);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_register(REG_REVERSE_TOL, 0);
          set_register(REG_PASS_THRESH, $urandom_range(1, 10));
          send_idle_pct = 72;
          recv_stall_pct = 0;
        end
        2: begin
          set_register(REG_REVERSE_TOL, $urandom_range(1, 6));
          set_register(REG_PASS_THRESH, $urandom_range(2, 12));
          send_idle_pct = 0;
          recv_stall_pct = 72;
        end
        default: begin
          set_register(REG_REVERSE_TOL, $urandom_range(0, 10));
          set_register(REG_PASS_THRESH, $urandom_range(0, 15));
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      start = queued_samples;
      while (queued_samples - start < 175) begin
        if ($urandom_range(99) < 15) begin
          add_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          add_pass_travel();
        end
      end
      if (phase == 2) begin
        hold_left = 60;
      end
      wait_idle();
    end

    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/qpv_pkg.sv
hdl/quadrature_pass_validator.sv
dv/tb_quadrature_pass_validator.sv
